### rtl/core/cttmtf_pkg.sv
// Shared types and constants for the call target tally move-to-front table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package cttmtf_pkg;

  // Table geometry
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned FillW      = $clog2(TableDepth + 1);

  // Field widths
  localparam int unsigned AddrW  = 24;
  localparam int unsigned CountW = 32;
  localparam int unsigned FlagW  = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned UsedW  = 11;
  localparam int unsigned EntryW = AddrW + CountW + FlagW;

  // One table entry; flags are {multi, mode_x, mode_m}
  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [CountW-1:0] count;
    logic [FlagW-1:0]  flags;
  } entry_t;

  // Table write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_HIT_NEW_SLOT,
    WR_HIT_OLD_SLOT,
    WR_APPEND
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    rd_first;
    logic    start;
    logic    scan_adv;
    logic    hit_latch;
    wr_sel_e wr_sel;
    logic    miss_end;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic match;
    logic last;
    logic full;
    logic front;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/cttmtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cttmtf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/cttmtf_ctrl.sv
// Sequencer for the table search, update/swap or append, and result hand-off.
// Depends on cttmtf_pkg.
`default_nettype none

module cttmtf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cttmtf_pkg::sts_t  sts_i,
  output cttmtf_pkg::cmd_t  cmd_o
);
  import cttmtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_HIT_WR,
    S_SWAP,
    S_MISS,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Decode commands and next state
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_sel   = WR_NONE;
    cmd_o.rd_first = (state_q == S_IDLE);
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.empty ? S_MISS : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.hit_latch = 1'b1;
          state_d         = S_HIT_WR;
        end else if (sts_i.last) begin
          state_d = S_MISS;
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      S_HIT_WR: begin
        cmd_o.wr_sel = WR_HIT_NEW_SLOT;
        state_d      = sts_i.front ? S_RESULT : S_SWAP;
      end
      S_SWAP: begin
        cmd_o.wr_sel = WR_HIT_OLD_SLOT;
        state_d      = S_RESULT;
      end
      S_MISS: begin
        cmd_o.wr_sel   = sts_i.full ? WR_NONE : WR_APPEND;
        cmd_o.miss_end = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free)
    else $error("result overwritten while pending");

  // A swap always follows the new-slot write of a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWAP) |-> $past(state_q == S_HIT_WR))
    else $error("swap without preceding hit write");

  // Search starts only after an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q == S_IDLE)) |-> $past(in_valid_i))
    else $error("search started without transaction");
`endif

endmodule

`default_nettype wire

### rtl/core/cttmtf_dp.sv
// Datapath: entry table RAM, search pointer, key, entry updates and result registers.
// Depends on cttmtf_pkg and cttmtf_ram.
`default_nettype none

module cttmtf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cttmtf_pkg::cmd_t                  cmd_i,
  output cttmtf_pkg::sts_t                  sts_o,
  input  logic [cttmtf_pkg::AddrW-1:0]      target_address_i,
  input  logic                              mode_m_i,
  input  logic                              mode_x_i,
  output logic                              hit_o,
  output logic                              dropped_o,
  output logic [cttmtf_pkg::SlotW-1:0]      slot_now_o,
  output logic [cttmtf_pkg::CountW-1:0]     count_now_o,
  output logic                              multi_now_o,
  output logic [cttmtf_pkg::UsedW-1:0]      entries_used_o
);
  import cttmtf_pkg::*;

  logic [IdxW-1:0]   ptr_q;
  logic [AddrW-1:0]  key_addr_q;
  logic [ModeW-1:0]  key_mode_q;
  entry_t            prev_q;
  entry_t            cur_q;
  logic [FillW-1:0]  fill_q;

  logic              res_hit_q;
  logic              res_drop_q;
  logic [IdxW-1:0]   res_slot_q;
  logic [CountW-1:0] res_count_q;
  logic              res_multi_q;

  logic              out_hit_q;
  logic              out_drop_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [CountW-1:0] out_count_q;
  logic              out_multi_q;
  logic [UsedW-1:0]  out_used_q;

  logic [IdxW-1:0]   rd_addr;
  logic [EntryW-1:0] rd_data;
  entry_t            rd_entry;
  entry_t            upd_entry;
  entry_t            new_entry;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_entry;
  logic [IdxW-1:0]   hit_slot;

  // Entry table
  cttmtf_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);
  // Read slot 0 while idle, then stay one slot ahead of the compare
  assign rd_addr  = cmd_i.rd_first ? '0 : IdxW'(ptr_q + 1'b1);

  // Status
  assign sts_o.empty = (fill_q == '0);
  assign sts_o.match = (rd_entry.addr == key_addr_q);
  assign sts_o.last  = ((FillW'(ptr_q) + FillW'(1)) == fill_q);
  assign sts_o.full  = (fill_q == FillW'(TableDepth));
  assign sts_o.front = (ptr_q == '0);

  assign hit_slot = sts_o.front ? ptr_q : IdxW'(ptr_q - 1'b1);

  // Saturating count, sticky multi-mode mark
  always_comb begin
    upd_entry.addr  = rd_entry.addr;
    upd_entry.count = (rd_entry.count == '1) ? rd_entry.count
                                             : CountW'(rd_entry.count + 1'b1);
    upd_entry.flags = {rd_entry.flags[2] | (rd_entry.flags[ModeW-1:0] != key_mode_q),
                       rd_entry.flags[ModeW-1:0]};
  end

  assign new_entry.addr  = key_addr_q;
  assign new_entry.count = CountW'(1);
  assign new_entry.flags = {1'b0, key_mode_q};

  // Select table write
  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = '0;
    wr_entry = cur_q;
    unique case (cmd_i.wr_sel)
      WR_NONE:         wr_en = 1'b0;
      WR_HIT_NEW_SLOT: begin
        wr_addr  = hit_slot;
        wr_entry = cur_q;
      end
      WR_HIT_OLD_SLOT: begin
        wr_addr  = ptr_q;
        wr_entry = prev_q;
      end
      WR_APPEND: begin
        wr_addr  = fill_q[IdxW-1:0];
        wr_entry = new_entry;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.miss_end && !sts_o.full) begin
      fill_q <= FillW'(fill_q + 1'b1);
    end
  end

  // Search, update and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ptr_q      <= '0;
      key_addr_q <= target_address_i;
      key_mode_q <= {mode_x_i, mode_m_i};
    end
    if (cmd_i.scan_adv) begin
      ptr_q  <= IdxW'(ptr_q + 1'b1);
      prev_q <= rd_entry;
    end
    if (cmd_i.hit_latch) begin
      cur_q       <= upd_entry;
      res_hit_q   <= 1'b1;
      res_drop_q  <= 1'b0;
      res_slot_q  <= hit_slot;
      res_count_q <= upd_entry.count;
      res_multi_q <= upd_entry.flags[2];
    end
    if (cmd_i.miss_end) begin
      res_hit_q   <= 1'b0;
      res_drop_q  <= sts_o.full;
      res_slot_q  <= sts_o.full ? '0 : fill_q[IdxW-1:0];
      res_count_q <= sts_o.full ? '0 : CountW'(1);
      res_multi_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_hit_q   <= res_hit_q;
      out_drop_q  <= res_drop_q;
      out_slot_q  <= SlotW'(res_slot_q);
      out_count_q <= res_count_q;
      out_multi_q <= res_multi_q;
      out_used_q  <= UsedW'(fill_q);
    end
  end

  assign hit_o          = out_hit_q;
  assign dropped_o      = out_drop_q;
  assign slot_now_o     = out_slot_q;
  assign count_now_o    = out_count_q;
  assign multi_now_o    = out_multi_q;
  assign entries_used_o = out_used_q;

`ifndef SYNTHESIS
  // Fill level never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(TableDepth))
    else $error("fill level beyond table depth");

  // Fill level grows by at most one per cycle and never shrinks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (fill_q == $past(fill_q)) ||
                      (fill_q == FillW'($past(fill_q) + 1'b1)))
    else $error("fill level stepped by more than one");

  // A dropped result carries no slot or count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) && out_drop_q |->
      !out_hit_q && (out_slot_q == '0) && (out_count_q == '0))
    else $error("dropped result with payload");

  // Appends only land in an unused slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_sel == WR_APPEND) |-> !sts_o.full)
    else $error("append into full table");
`endif

endmodule

`default_nettype wire

### rtl/core/call_target_tally_move_to_front.sv
// Call target tally with move-to-front ordering: one search/update per call event.
// The result of an event is presented after its search, its table writes and any wait
// for the previous result to leave the output register. The search compares slots up
// to the fill level, at most 1024, reading the entry table through its single
// registered read port, one slot per cycle; a hit then costs one or two table writes
// for the update and the swap toward the front, a miss one append write unless the
// table is full. One event is worked at a time; a finished result sits in an output
// register, so the next event is taken while that result waits. The table is empty
// after reset and needs no clearing pass. Depends on cttmtf_pkg, cttmtf_ctrl,
// cttmtf_dp.
`default_nettype none

module call_target_tally_move_to_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cttmtf_pkg::AddrW-1:0]      target_address_i,
  input  logic                              mode_m_i,
  input  logic                              mode_x_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic                              dropped_o,
  output logic [cttmtf_pkg::SlotW-1:0]      slot_now_o,
  output logic [cttmtf_pkg::CountW-1:0]     count_now_o,
  output logic                              multi_now_o,
  output logic [cttmtf_pkg::UsedW-1:0]      entries_used_o
);
  import cttmtf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cttmtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table and result datapath
  cttmtf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .target_address_i (target_address_i),
    .mode_m_i         (mode_m_i),
    .mode_x_i         (mode_x_i),
    .hit_o            (hit_o),
    .dropped_o        (dropped_o),
    .slot_now_o       (slot_now_o),
    .count_now_o      (count_now_o),
    .multi_now_o      (multi_now_o),
    .entries_used_o   (entries_used_o)
  );

endmodule

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for call_target_tally_move_to_front.
// Drives call events through a burst/gap driver, predicts every result with an
// in-bench move-to-front tally table, and checks each result transaction.
// Depends on cttmtf_pkg and the call_target_tally_move_to_front RTL.

module tb_top;
  import cttmtf_pkg::*;

  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned SettleCycles = 1100;
  localparam int unsigned HotSlots    = 8;

  // One queued call event; drain holds it back until every result is in
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ModeW-1:0] mode;
    logic             drain;
  } call_t;

  // Expected result transaction
  typedef struct packed {
    logic              hit;
    logic              dropped;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic              multi;
    logic [UsedW-1:0]  used;
  } tally_res_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_e;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [AddrW-1:0]  target_address = '0;
  logic              mode_m         = 1'b0;
  logic              mode_x         = 1'b0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic              hit;
  logic              dropped;
  logic [SlotW-1:0]  slot_now;
  logic [CountW-1:0] count_now;
  logic              multi_now;
  logic [UsedW-1:0]  entries_used;

  call_t       calls_pending[$];
  tally_res_t  tally_expected[$];

  // Predicted table contents
  entry_t           tally_tab [TableDepth];
  logic [UsedW-1:0] tally_fill = '0;

  // Generator bookkeeping: addresses that land in the table, with their first mode
  logic [AddrW-1:0] stored_addrs[$];
  logic [ModeW-1:0] first_mode [int unsigned];

  int unsigned calls_total  = 0;
  int unsigned calls_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  logic        in_acc       = 1'b0;

  call_target_tally_move_to_front u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .target_address_i (target_address),
    .mode_m_i         (mode_m),
    .mode_x_i         (mode_x),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .hit_o            (hit),
    .dropped_o        (dropped),
    .slot_now_o       (slot_now),
    .count_now_o      (count_now),
    .multi_now_o      (multi_now),
    .entries_used_o   (entries_used)
  );

  always #1 clk_i = ~clk_i;

  // Apply one call event to the predicted table and return its result
  function automatic tally_res_t tally_update(logic [AddrW-1:0] addr, logic [ModeW-1:0] mode);
    tally_res_t res;
    entry_t     ent;
    int         idx;
    int         i;
    res = '0;
    idx = -1;
    for (i = 0; i < int'(tally_fill); i++) begin
      if (idx < 0 && tally_tab[i].addr == addr) idx = i;
    end
    if (idx >= 0) begin
      // Count with saturation, set the sticky mark, move one slot forward
      ent = tally_tab[idx];
      if (ent.count != '1) ent.count = ent.count + 1'b1;
      if (ent.flags[ModeW-1:0] != mode) ent.flags[FlagW-1] = 1'b1;
      if (idx > 0) begin
        tally_tab[idx] = tally_tab[idx-1];
        idx = idx - 1;
      end
      tally_tab[idx] = ent;
      res.hit   = 1'b1;
      res.slot  = SlotW'(idx);
      res.count = ent.count;
      res.multi = ent.flags[FlagW-1];
    end else if (tally_fill < TableDepth) begin
      // Append at the fill level
      ent.addr  = addr;
      ent.count = 1;
      ent.flags = {1'b0, mode};
      tally_tab[tally_fill] = ent;
      res.slot   = SlotW'(tally_fill);
      res.count  = 1;
      tally_fill = tally_fill + 1'b1;
    end else begin
      res.dropped = 1'b1;
    end
    res.used = tally_fill;
    return res;
  endfunction

  // Print one line per mismatch and count it
  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Queue a call; track which addresses end up stored in the table
  task automatic push_call(logic [AddrW-1:0] addr, logic [ModeW-1:0] mode, bit drain);
    call_t c;
    c.addr  = addr;
    c.mode  = mode;
    c.drain = drain;
    calls_pending.push_back(c);
    if (!first_mode.exists(addr) && stored_addrs.size() < TableDepth) begin
      first_mode[addr] = mode;
      stored_addrs.push_back(addr);
    end
  endtask

  function automatic logic [AddrW-1:0] fresh_address();
    logic [AddrW-1:0] a;
    a = AddrW'($urandom());
    while (first_mode.exists(a)) a = AddrW'($urandom());
    return a;
  endfunction

  function automatic logic [AddrW-1:0] pick_stored(bit hot);
    int unsigned top;
    top = stored_addrs.size() - 1;
    if (hot && top > HotSlots - 1) top = HotSlots - 1;
    return stored_addrs[$urandom_range(0, top)];
  endfunction

  // Mostly keep the stored flags so that many entries stay single-mode
  function automatic logic [ModeW-1:0] pick_mode(logic [AddrW-1:0] addr);
    if (first_mode.exists(addr) && $urandom_range(0, 2) != 0) return first_mode[addr];
    return ModeW'($urandom_range(0, 3));
  endfunction

  // Driver: present queued calls in bursts with random gaps
  always @(negedge clk_i) begin : driver
    call_t       nxt;
    int unsigned burst_left;
    int unsigned gap_left;
    if (rst_ni && (!in_valid || in_acc)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (calls_pending.size() != 0 &&
                   !(calls_pending[0].drain && tally_expected.size() != 0)) begin
        nxt = calls_pending.pop_front();
        in_valid       <= 1'b1;
        target_address <= nxt.addr;
        mode_m         <= nxt.mode[0];
        mode_x         <= nxt.mode[1];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a mode that is redrawn at random
  always @(negedge clk_i) begin : receiver
    rx_mode_e    rx_mode;
    int unsigned rx_left;
    int unsigned rx_step;
    logic [7:0]  rx_pat;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
      rx_pat  = 8'($urandom());
    end else begin
      rx_left--;
    end
    rx_step++;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 11) == 0);
        default:   out_ready <= rx_pat[rx_step % 8];
      endcase
    end
  end

  // Monitor: check result transactions, predict accepted calls, watch for a hang
  always @(posedge clk_i) begin : monitor
    tally_res_t want;
    in_acc <= rst_ni && in_valid && in_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (tally_expected.size() == 0) begin
          report_mismatch("result with no call event pending");
        end else begin
          want = tally_expected.pop_front();
          check_field("hit", hit, want.hit);
          check_field("dropped", dropped, want.dropped);
          check_field("slot_now", slot_now, want.slot);
          check_field("count_now", count_now, want.count);
          check_field("multi_now", multi_now, want.multi);
          check_field("entries_used", entries_used, want.used);
        end
      end
      if (in_valid && in_ready) begin
        tally_expected.push_back(tally_update(target_address, {mode_x, mode_m}));
        calls_taken++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] prev;
    int unsigned      roll;
    int               n;

    // Directed: extremes, front hits, swaps, flag changes
    push_call(24'h000000, 2'b00, 1'b0);
    push_call(24'hffffff, 2'b11, 1'b0);
    push_call(24'h000000, 2'b00, 1'b0);  // hit already in front
    push_call(24'hffffff, 2'b11, 1'b0);  // hit in slot 1, moves to front
    push_call(24'hffffff, 2'b10, 1'b0);  // differing flags set the mark
    push_call(24'hffffff, 2'b11, 1'b0);  // mark stays set
    push_call(24'h800000, 2'b01, 1'b0);
    push_call(24'h000001, 2'b10, 1'b0);
    push_call(24'h800000, 2'b10, 1'b0);
    push_call(24'h000001, 2'b10, 1'b0);  // walk toward front one slot per hit
    push_call(24'h000001, 2'b10, 1'b0);
    push_call(24'h000001, 2'b10, 1'b0);
    push_call(24'h000001, 2'b10, 1'b0);
    push_call(24'h555555, 2'b01, 1'b0);
    push_call(24'haaaaaa, 2'b10, 1'b0);
    push_call(24'h555555, 2'b11, 1'b0);

    // Random mix on a growing table; the first one waits for an empty pipe
    prev = 24'h555555;
    for (n = 0; n < 384; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) a = prev;
      else if (roll < 40) a = pick_stored(1'b1);
      else if (roll < 60) a = pick_stored(1'b0);
      else a = fresh_address();
      push_call(a, pick_mode(a), n == 0);
      prev = a;
    end
    calls_total = calls_pending.size();

    // Hold reset, then release away from the rising edge
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all calls and results, then let the block settle
    while (calls_taken != calls_total) @(negedge clk_i);
    while (tally_expected.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
